// File: rtl/core/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg: shared types and constants for the JSON string escaper
// Token kinds, escape characters, UTF-8 lead and continuation bounds and the
// lower-case hex digit helper.
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

  // One token expands to one, two or six output bytes
  typedef enum logic [1:0] {
    TOK_RAW   = 2'd0,
    TOK_SHORT = 2'd1,
    TOK_ESC   = 2'd2
  } tok_kind_t;

  localparam logic [2:0] RAW_TOP   = 3'd0;
  localparam logic [2:0] SHORT_TOP = 3'd1;
  localparam logic [2:0] ESC_TOP   = 3'd5;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_TOP = 8'h20;

  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hBF;
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;
  localparam logic [7:0] LEAD_E0   = 8'hE0;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] LEAD_F0   = 8'hF0;
  localparam logic [7:0] LEAD_F4   = 8'hF4;
  localparam logic [7:0] E0_CONT_LO = 8'hA0;
  localparam logic [7:0] ED_CONT_HI = 8'h9F;
  localparam logic [7:0] F0_CONT_LO = 8'h90;
  localparam logic [7:0] F4_CONT_HI = 8'h8F;

  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'd0, v};
    end else begin
      r = CH_LOW_A + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/json_string_escaper_utf8_check_core.sv
// ----------------------------------------------------------------------------
// json_string_escaper_utf8_check_core: JSON string body escaper
// Escapes a byte stream for a JSON string body and checks UTF-8 on the fly.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one source byte per request, with
//   in_end_of_string on the final byte of a string. Output channel
//   (out_valid/out_ready) gives the escaped body one byte per request, with
//   out_last on the final byte of the string. No surrounding quotes.
//   A request is planned in the cycle it is accepted into a token register
//   of up to four tokens (raw byte, two-byte short escape, six-byte \u00xx),
//   then serialized into the output register, so the first output byte
//   passes through both registers on its way out.
//   Throughput: a request that yields no byte (a held UTF-8 lead or
//   continuation byte) leaves the input ready; otherwise a request occupies
//   the serializer until it has handed over all its bytes (up to 24). The next
//   request is taken in the cycle the current one hands its last byte over.
//   Reset (rst_n low, synchronous) empties the held sequence and both
//   registers. When the receiver stalls, the output register holds its byte
//   and the serializer and input side stall behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escaper_utf8_check_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_string,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  // held UTF-8 sequence state
  logic [7:0] held_r [3];
  logic [1:0] held_cnt_r;
  logic [2:0] seq_len_r;

  // token register
  logic                job_valid_r;
  jse_pkg::tok_kind_t  tok_kind_r [4];
  logic [7:0]          tok_val_r [4];
  logic [1:0]          tok_top_r;
  logic                job_last_r;
  logic [1:0]          tok_idx_r;
  logic [2:0]          byte_idx_r;

  // output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  // plan signals
  logic [7:0]         held_nxt [3];
  logic [1:0]         held_cnt_nxt;
  logic [2:0]         seq_len_nxt;
  logic               fits;
  logic               do_fresh;
  logic [2:0]         na;
  jse_pkg::tok_kind_t a_kind;
  logic [2:0]         nb;
  jse_pkg::tok_kind_t b_kind;
  logic [7:0]         b_val;
  logic [2:0]         nc;
  logic [2:0]         plan_cnt;
  jse_pkg::tok_kind_t plan_kind [4];
  logic [7:0]         plan_val [4];
  logic               fr_hold;
  logic [2:0]         fr_seq;
  jse_pkg::tok_kind_t fr_kind;
  logic [7:0]         fr_val;

  // serializer signals
  logic               in_fire;
  logic               out_load;
  jse_pkg::tok_kind_t cur_kind;
  logic [7:0]         cur_val;
  logic [2:0]         cur_top;
  logic               byte_final;
  logic               job_final;
  logic [7:0]         cur_byte;

  function automatic logic [7:0] pick3(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = b0;
      2'd1:    r = b1;
      default: r = b2;
    endcase
    return r;
  endfunction

  // continuation check, with the narrowed second-byte ranges
  always_comb begin
    fits = (in_data_byte >= jse_pkg::CONT_LO) && (in_data_byte <= jse_pkg::CONT_HI);
    if (held_cnt_r == 2'd1) begin
      unique case (held_r[0])
        jse_pkg::LEAD_E0: fits = (in_data_byte >= jse_pkg::E0_CONT_LO) &&
                                 (in_data_byte <= jse_pkg::CONT_HI);
        jse_pkg::LEAD_ED: fits = (in_data_byte >= jse_pkg::CONT_LO) &&
                                 (in_data_byte <= jse_pkg::ED_CONT_HI);
        jse_pkg::LEAD_F0: fits = (in_data_byte >= jse_pkg::F0_CONT_LO) &&
                                 (in_data_byte <= jse_pkg::CONT_HI);
        jse_pkg::LEAD_F4: fits = (in_data_byte >= jse_pkg::CONT_LO) &&
                                 (in_data_byte <= jse_pkg::F4_CONT_HI);
        default: ;
      endcase
    end
  end

  // classify a byte that starts afresh
  always_comb begin
    fr_hold = 1'b0;
    fr_seq  = jse_pkg::SEQ_NONE;
    fr_kind = jse_pkg::TOK_RAW;
    fr_val  = in_data_byte;
    unique case (in_data_byte)
      jse_pkg::CH_QUOTE:  begin fr_kind = jse_pkg::TOK_SHORT; fr_val = jse_pkg::CH_QUOTE;  end
      jse_pkg::CH_BSLASH: begin fr_kind = jse_pkg::TOK_SHORT; fr_val = jse_pkg::CH_BSLASH; end
      jse_pkg::CTL_BS:    begin fr_kind = jse_pkg::TOK_SHORT; fr_val = jse_pkg::CH_B;      end
      jse_pkg::CTL_FF:    begin fr_kind = jse_pkg::TOK_SHORT; fr_val = jse_pkg::CH_F;      end
      jse_pkg::CTL_LF:    begin fr_kind = jse_pkg::TOK_SHORT; fr_val = jse_pkg::CH_N;      end
      jse_pkg::CTL_CR:    begin fr_kind = jse_pkg::TOK_SHORT; fr_val = jse_pkg::CH_R;      end
      jse_pkg::CTL_TAB:   begin fr_kind = jse_pkg::TOK_SHORT; fr_val = jse_pkg::CH_T;      end
      default: begin
        if (in_data_byte < jse_pkg::CTL_TOP) begin
          fr_kind = jse_pkg::TOK_ESC;
        end else if (in_data_byte < jse_pkg::CONT_LO) begin
          fr_kind = jse_pkg::TOK_RAW;
        end else if (in_data_byte >= jse_pkg::LEAD2_LO && in_data_byte <= jse_pkg::LEAD2_HI) begin
          fr_hold = 1'b1;
          fr_seq  = jse_pkg::SEQ_TWO;
        end else if (in_data_byte >= jse_pkg::LEAD3_LO && in_data_byte <= jse_pkg::LEAD3_HI) begin
          fr_hold = 1'b1;
          fr_seq  = jse_pkg::SEQ_THREE;
        end else if (in_data_byte >= jse_pkg::LEAD4_LO && in_data_byte <= jse_pkg::LEAD4_HI) begin
          fr_hold = 1'b1;
          fr_seq  = jse_pkg::SEQ_FOUR;
        end else begin
          fr_kind = jse_pkg::TOK_ESC;
        end
      end
    endcase
  end

  // plan: held tokens, then the fresh token, then the end-of-string flush
  always_comb begin
    held_nxt     = held_r;
    held_cnt_nxt = 2'd0;
    seq_len_nxt  = jse_pkg::SEQ_NONE;
    na           = 3'd0;
    a_kind       = jse_pkg::TOK_RAW;
    nb           = 3'd0;
    b_kind       = jse_pkg::TOK_RAW;
    b_val        = in_data_byte;
    do_fresh     = 1'b1;
    if (held_cnt_r != 2'd0) begin
      if (fits) begin
        do_fresh = 1'b0;
        if ({1'b0, held_cnt_r} + 3'd1 == seq_len_r) begin
          na = {1'b0, held_cnt_r};
          nb = 3'd1;
        end else begin
          case (held_cnt_r)
            2'd1:    held_nxt[1] = in_data_byte;
            default: held_nxt[2] = in_data_byte;
          endcase
          held_cnt_nxt = held_cnt_r + 2'd1;
          seq_len_nxt  = seq_len_r;
        end
      end else begin
        na     = {1'b0, held_cnt_r};
        a_kind = jse_pkg::TOK_ESC;
      end
    end
    if (do_fresh) begin
      if (fr_hold) begin
        held_nxt[0]  = in_data_byte;
        held_cnt_nxt = 2'd1;
        seq_len_nxt  = fr_seq;
      end else begin
        nb     = 3'd1;
        b_kind = fr_kind;
        b_val  = fr_val;
      end
    end
    nc       = in_end_of_string ? {1'b0, held_cnt_nxt} : 3'd0;
    plan_cnt = na + nb + nc;
    for (int k = 0; k < 4; k++) begin
      logic [2:0] kk;
      logic [2:0] ci;
      kk = 3'(k);
      ci = kk - na - nb;
      if (kk < na) begin
        plan_kind[k] = a_kind;
        plan_val[k]  = pick3(held_r[0], held_r[1], held_r[2], kk[1:0]);
      end else if (kk < na + nb) begin
        plan_kind[k] = b_kind;
        plan_val[k]  = b_val;
      end else begin
        plan_kind[k] = jse_pkg::TOK_ESC;
        plan_val[k]  = pick3(held_nxt[0], held_nxt[1], held_nxt[2], ci[1:0]);
      end
    end
  end

  // serializer
  always_comb begin
    cur_kind = tok_kind_r[tok_idx_r];
    cur_val  = tok_val_r[tok_idx_r];
    unique case (cur_kind)
      jse_pkg::TOK_SHORT: cur_top = jse_pkg::SHORT_TOP;
      jse_pkg::TOK_ESC:   cur_top = jse_pkg::ESC_TOP;
      default:            cur_top = jse_pkg::RAW_TOP;
    endcase
    unique case (cur_kind)
      jse_pkg::TOK_SHORT: cur_byte = (byte_idx_r == 3'd0) ? jse_pkg::CH_BSLASH : cur_val;
      jse_pkg::TOK_ESC: begin
        case (byte_idx_r)
          3'd0:    cur_byte = jse_pkg::CH_BSLASH;
          3'd1:    cur_byte = jse_pkg::CH_U;
          3'd2:    cur_byte = jse_pkg::CH_ZERO;
          3'd3:    cur_byte = jse_pkg::CH_ZERO;
          3'd4:    cur_byte = jse_pkg::hex_digit(cur_val[7:4]);
          default: cur_byte = jse_pkg::hex_digit(cur_val[3:0]);
        endcase
      end
      default: cur_byte = cur_val;
    endcase
    byte_final = (byte_idx_r == cur_top);
    job_final  = byte_final && (tok_idx_r == tok_top_r);
  end

  assign out_load  = job_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !job_valid_r || (out_load && job_final);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r  <= 2'd0;
      seq_len_r   <= jse_pkg::SEQ_NONE;
      job_valid_r <= 1'b0;
      tok_idx_r   <= 2'd0;
      byte_idx_r  <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        // a flagged byte always leaves the sequence empty
        held_cnt_r  <= in_end_of_string ? 2'd0 : held_cnt_nxt;
        seq_len_r   <= in_end_of_string ? jse_pkg::SEQ_NONE : seq_len_nxt;
        job_valid_r <= (plan_cnt != 3'd0);
        tok_idx_r   <= 2'd0;
        byte_idx_r  <= 3'd0;
      end else if (out_load) begin
        if (job_final) begin
          job_valid_r <= 1'b0;
        end else if (byte_final) begin
          tok_idx_r  <= tok_idx_r + 2'd1;
          byte_idx_r <= 3'd0;
        end else begin
          byte_idx_r <= byte_idx_r + 3'd1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_r     <= held_nxt;
      tok_kind_r <= plan_kind;
      tok_val_r  <= plan_val;
      tok_top_r  <= plan_cnt[1:0] - 2'd1;
      job_last_r <= in_end_of_string;
    end
    if (out_load) begin
      out_byte_r <= cur_byte;
      out_last_r <= job_last_r && job_final;
    end
  end

endmodule

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for json_string_escaper_utf8_check_core
// Feeds directed and random byte strings through the escaper under varying
// sender idling and receiver stalls. A scoreboard predicts the escaped byte
// stream with its own UTF-8 tracker and checks every output byte in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEMS_PER_PHASE = 65;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } escaped_byte_t;

  // Predicts the escaped stream and holds the bytes still owed by the block
  class escape_scoreboard;
    escaped_byte_t owed_q[$];
    escaped_byte_t step_q[$];
    logic [7:0]    held [3];
    logic [1:0]    held_n;
    logic [2:0]    seq_len;
    int            errors;
    int            checked;

    function new();
      held_n  = 2'd0;
      seq_len = jse_pkg::SEQ_NONE;
      errors  = 0;
      checked = 0;
    endfunction

    function void emit(logic [7:0] b);
      escaped_byte_t e;
      e.data = b;
      e.last = 1'b0;
      step_q.push_back(e);
    endfunction

    function void emit_u00(logic [7:0] b);
      string digits;
      digits = "0123456789abcdef";
      emit(jse_pkg::CH_BSLASH);
      emit(jse_pkg::CH_U);
      emit(jse_pkg::CH_ZERO);
      emit(jse_pkg::CH_ZERO);
      emit(digits[b[7:4]]);
      emit(digits[b[3:0]]);
    endfunction

    function void emit_short(logic [7:0] c);
      emit(jse_pkg::CH_BSLASH);
      emit(c);
    endfunction

    function void flush_held();
      for (int i = 0; i < held_n; i++) emit_u00(held[i]);
      held_n  = 2'd0;
      seq_len = jse_pkg::SEQ_NONE;
    endfunction

    function bit fits(logic [7:0] b);
      if (held_n == 2'd1) begin
        case (held[0])
          jse_pkg::LEAD_E0: return b >= jse_pkg::E0_CONT_LO && b <= jse_pkg::CONT_HI;
          jse_pkg::LEAD_ED: return b >= jse_pkg::CONT_LO && b <= jse_pkg::ED_CONT_HI;
          jse_pkg::LEAD_F0: return b >= jse_pkg::F0_CONT_LO && b <= jse_pkg::CONT_HI;
          jse_pkg::LEAD_F4: return b >= jse_pkg::CONT_LO && b <= jse_pkg::F4_CONT_HI;
          default: ;
        endcase
      end
      return b >= jse_pkg::CONT_LO && b <= jse_pkg::CONT_HI;
    endfunction

    // Escape or pass a byte outside any sequence; a valid lead opens one
    function void open_byte(logic [7:0] b);
      case (b)
        jse_pkg::CH_QUOTE:  emit_short(jse_pkg::CH_QUOTE);
        jse_pkg::CH_BSLASH: emit_short(jse_pkg::CH_BSLASH);
        jse_pkg::CTL_BS:    emit_short(jse_pkg::CH_B);
        jse_pkg::CTL_FF:    emit_short(jse_pkg::CH_F);
        jse_pkg::CTL_LF:    emit_short(jse_pkg::CH_N);
        jse_pkg::CTL_CR:    emit_short(jse_pkg::CH_R);
        jse_pkg::CTL_TAB:   emit_short(jse_pkg::CH_T);
        default: begin
          if (b < jse_pkg::CTL_TOP) begin
            emit_u00(b);
          end else if (b < jse_pkg::CONT_LO) begin
            emit(b);
          end else begin
            if (b >= jse_pkg::LEAD2_LO && b <= jse_pkg::LEAD2_HI) begin
              seq_len = jse_pkg::SEQ_TWO;
            end else if (b >= jse_pkg::LEAD3_LO && b <= jse_pkg::LEAD3_HI) begin
              seq_len = jse_pkg::SEQ_THREE;
            end else if (b >= jse_pkg::LEAD4_LO && b <= jse_pkg::LEAD4_HI) begin
              seq_len = jse_pkg::SEQ_FOUR;
            end
            if (seq_len == jse_pkg::SEQ_NONE) begin
              emit_u00(b);
            end else begin
              held[0] = b;
              held_n  = 2'd1;
            end
          end
        end
      endcase
    endfunction

    function void note_request(logic [7:0] b, logic eos);
      step_q.delete();
      if (held_n != 2'd0 && seq_len > {1'b0, held_n}) begin
        if (fits(b)) begin
          if ({1'b0, held_n} + 3'd1 == seq_len) begin
            for (int i = 0; i < held_n; i++) emit(held[i]);
            emit(b);
            held_n  = 2'd0;
            seq_len = jse_pkg::SEQ_NONE;
          end else begin
            held[held_n] = b;
            held_n++;
          end
        end else begin
          flush_held();
          open_byte(b);
        end
      end else begin
        held_n  = 2'd0;
        seq_len = jse_pkg::SEQ_NONE;
        open_byte(b);
      end
      if (eos) begin
        if (held_n != 2'd0) flush_held();
        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      end
      foreach (step_q[i]) owed_q.push_back(step_q[i]);
    endfunction

    function void check_result(logic [7:0] b, logic last);
      escaped_byte_t want;
      checked++;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output byte %h last %b", $time, b, last);
        return;
      end
      want = owed_q.pop_front();
      if (want.data !== b) begin
        errors++;
        $display("%0t: out_byte expected %h actual %h", $time, want.data, b);
      end
      if (want.last !== last) begin
        errors++;
        $display("%0t: out_last expected %b actual %b", $time, want.last, last);
      end
    endfunction

    function int owed();
      return owed_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_string = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  escape_scoreboard sb = new();
  int send_idle_pct = 0;
  int out_stall_pct = 0;
  int request_count = 0;
  int string_count  = 0;
  int cycle_count   = 0;
  logic [7:0] str_q[$];

  json_string_escaper_utf8_check_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last         (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Note the request before checking output so a same-edge result finds it
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_data_byte, in_end_of_string);
    if (rst_n && out_valid && out_ready) sb.check_result(out_byte, out_last);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes still owed", $time, sb.owed());
      $display("FAIL json_string_escaper_utf8_check_core");
      $finish;
    end
  end

  task automatic send_request(input logic [7:0] b, input logic eos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_string <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    request_count++;
  endtask

  task automatic send_string();
    foreach (str_q[i]) send_request(str_q[i], i == str_q.size() - 1);
    string_count++;
    str_q.delete();
  endtask

  // Hold off the sender until the block has handed over everything owed
  task automatic wait_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed() != 0) @(posedge clk);
  endtask

  // Push the first keep bytes of a well-formed character of len bytes
  task automatic add_char(input int len, input int keep);
    logic [7:0] seq [4];
    int lo;
    int hi;
    lo = jse_pkg::CONT_LO;
    hi = jse_pkg::CONT_HI;
    case (len)
      1: seq[0] = 8'($urandom_range(jse_pkg::CTL_TOP, 8'h7E));
      2: seq[0] = 8'($urandom_range(jse_pkg::LEAD2_LO, jse_pkg::LEAD2_HI));
      3: seq[0] = 8'($urandom_range(jse_pkg::LEAD3_LO, jse_pkg::LEAD3_HI));
      default: seq[0] = 8'($urandom_range(jse_pkg::LEAD4_LO, jse_pkg::LEAD4_HI));
    endcase
    case (seq[0])
      jse_pkg::LEAD_E0: lo = jse_pkg::E0_CONT_LO;
      jse_pkg::LEAD_ED: hi = jse_pkg::ED_CONT_HI;
      jse_pkg::LEAD_F0: lo = jse_pkg::F0_CONT_LO;
      jse_pkg::LEAD_F4: hi = jse_pkg::F4_CONT_HI;
      default: ;
    endcase
    seq[1] = 8'($urandom_range(lo, hi));
    seq[2] = 8'($urandom_range(jse_pkg::CONT_LO, jse_pkg::CONT_HI));
    seq[3] = 8'($urandom_range(jse_pkg::CONT_LO, jse_pkg::CONT_HI));
    for (int i = 0; i < keep; i++) str_q.push_back(seq[i]);
  endtask

  task automatic build_random_string();
    int pieces;
    int roll;
    int len;
    pieces = $urandom_range(1, 8);
    repeat (pieces) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        add_char(1, 1);
      end else if (roll < 35) begin
        case ($urandom_range(0, 3))
          0: str_q.push_back(jse_pkg::CH_QUOTE);
          1: str_q.push_back(jse_pkg::CH_BSLASH);
          2: str_q.push_back(8'h7F);
          default: str_q.push_back(8'($urandom_range(0, jse_pkg::CTL_TOP - 1)));
        endcase
      end else if (roll < 72) begin
        len = (roll < 50) ? 2 : (roll < 62) ? 3 : 4;
        add_char(len, len);
      end else if (roll < 85) begin
        // cut-short character, then any byte, which may or may not break it
        len = $urandom_range(2, 4);
        add_char(len, $urandom_range(1, len - 1));
        str_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        str_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    // now and then cut the string off inside a character
    if ($urandom_range(0, 99) < 15) begin
      len = $urandom_range(2, 4);
      add_char(len, $urandom_range(1, len - 1));
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int start_count;
    send_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    start_count   = request_count;
    while (request_count - start_count < ITEMS_PER_PHASE) begin
      build_random_string();
      send_string();
    end
    wait_empty();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short escapes, control and edge ASCII, lone continuation and invalid lead bytes
    str_q = '{jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH, jse_pkg::CTL_BS,
              jse_pkg::CTL_FF, jse_pkg::CTL_LF, jse_pkg::CTL_CR, jse_pkg::CTL_TAB,
              8'h00, 8'h1F, 8'h7F, 8'h80, 8'hF5, 8'hFF};
    send_string();
    // boundary characters, then a surrogate lead broken by its second byte
    str_q = '{8'hC2, 8'h80, 8'hE0, 8'hA0, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
              8'hED, 8'hA0};
    send_string();
    // three held bytes broken by a new lead that the string end then cuts off
    str_q = '{8'hF0, 8'h90, 8'h80, 8'hE0};
    send_string();
    wait_empty();

    run_phase(0, 0);
    run_phase(58, 0);
    run_phase(0, 58);
    run_phase(15, 15);

    out_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.owed() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected bytes never came out", $time, sb.owed());
    end
    $display("Sent %0d bytes in %0d strings; checked %0d escaped bytes, %0d mismatches",
             request_count, string_count, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS json_string_escaper_utf8_check_core");
    end else begin
      $display("FAIL json_string_escaper_utf8_check_core");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/jse_pkg.sv
rtl/core/json_string_escaper_utf8_check_core.sv
test/tb.sv
